/* rtl/tgds_pkg.sv */
// shared types, constants and helpers of the task group dependency scheduler
`default_nettype none

package tgds_pkg;

  localparam int OpW      = 2;
  localparam int EvW      = 3;
  localparam int MaskW    = 32;
  localparam int GrpW     = 5;
  localparam int InTaskW  = 16;
  localparam int OutTaskW = 16;
  localparam int WaitW    = 6;

  typedef enum logic [OpW-1:0] {
    OP_SUBMIT = 2'd0,
    OP_DONE   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  typedef enum logic [EvW-1:0] {
    EV_ACCEPTED = 3'd0,
    EV_READY    = 3'd1,
    EV_FINISHED = 3'd2,
    EV_IDLE     = 3'd3,
    EV_CLEARED  = 3'd4,
    EV_REJECTED = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB,
    ST_SUB_RDY,
    ST_TD_CHK,
    ST_TD_ACC,
    ST_TD_FIN,
    ST_WALK,
    ST_IDLE_EV,
    ST_CLR,
    ST_REJ,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    event_e                ev;
    logic [GrpW-1:0]       grp;
    logic [OutTaskW-1:0]   tasks;
  } result_t;

  typedef struct packed {
    logic    push;
    logic    flush;
    result_t res;
  } emit_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } emit_stat_t;

  function automatic logic [WaitW-1:0] popcount32(input logic [MaskW-1:0] v);
    logic [WaitW-1:0] n;
    n = '0;
    for (int i = 0; i < MaskW; i++) begin
      n = n + WaitW'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/task_group_dependency_scheduler.sv */
// on task done, a finished group starts a release walk over every allocated group above it;
// the walk reads the task and dependency rams one entry per cycle, held while a released
// group's result waits on output backpressure
// one item at a time: the next transfer is taken only after the last result of the item
// has entered the output register; output backpressure holds the item back
// reset clears the group counters and status flags; the table rams are not cleared
`default_nettype none

module task_group_dependency_scheduler #(
  parameter int MAX_GROUPS      = 32,
  parameter int TASK_COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tgds_pkg::OpW-1:0]      opcode_i,
  input  logic [tgds_pkg::InTaskW-1:0]  task_count_i,
  input  logic [tgds_pkg::MaskW-1:0]    dep_mask_i,
  input  logic [tgds_pkg::GrpW-1:0]     done_group_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tgds_pkg::EvW-1:0]      event_res_o,
  output logic [tgds_pkg::GrpW-1:0]     group_num_o,
  output logic [tgds_pkg::OutTaskW-1:0] group_tasks_o,
  output logic                          last_o
);

  import tgds_pkg::*;

  localparam int GW  = $clog2(MAX_GROUPS);
  localparam int UW  = $clog2(MAX_GROUPS + 1);
  localparam int CW  = (UW > GrpW + 1) ? UW : GrpW + 1;
  localparam int TcW = TASK_COUNT_BITS;
  localparam int AW  = 2 * TcW;
  localparam int BW  = WaitW + MaskW;

  state_e state_q, state_d;
  logic [UW-1:0]         used_q, used_d;
  logic [UW-1:0]         active_q, active_d;
  logic [MAX_GROUPS-1:0] disp_q, disp_d;
  logic [MAX_GROUPS-1:0] done_q, done_d;
  logic [OpW-1:0]        op_q, op_d;
  logic [TcW-1:0]        tc_q, tc_d;
  logic [MaskW-1:0]      pend_q, pend_d;
  logic [GrpW-1:0]       dg_q, dg_d;
  logic [TcW-1:0]        total_q, total_d;
  logic [UW-1:0]         widx_q, widx_d;
  logic [MaskW-1:0]      fin_q, fin_d;

  emit_t      emit;
  emit_stat_t stat;

  logic          we_a, we_b;
  logic [GW-1:0] waddr_a, waddr_b, raddr_a, walk_raddr;
  logic [AW-1:0] wdata_a, rdata_a;
  logic [BW-1:0] wdata_b, rdata_b;

  logic [63:0]      done_ext;
  logic [MaskW-1:0] alloc, pend_in;
  logic             full, pend_zero, tc_zero;
  logic [GW-1:0]    g_idx, d_idx, w_idx;
  logic [GrpW-1:0]  g_prev;
  logic [TcW-1:0]   tot_a, fcnt_a, fcnt_inc;
  logic             dg_ok, td_rej, td_fin;
  logic [UW-1:0]    walk_start, w_nxt, act_walk;
  logic             start_more;
  logic [WaitW-1:0] waits_b, k_cnt, w_new;
  logic [MaskW-1:0] dep_b;
  logic             w_hit, w_rel, w_stall, w_zero, w_more;

  tgds_ram #(.Width(AW), .Depth(MAX_GROUPS)) u_ram_tasks (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (wdata_a),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  tgds_ram #(.Width(BW), .Depth(MAX_GROUPS)) u_ram_deps (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (wdata_b),
    .raddr_i (walk_raddr),
    .rdata_o (rdata_b)
  );

  tgds_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .group_num_o   (group_num_o),
    .group_tasks_o (group_tasks_o),
    .last_o        (last_o)
  );

  assign in_ready_o = (state_q == ST_IDLE);

  // shared conditions
  always_comb begin
    done_ext = 64'(done_q);
    for (int d = 0; d < MaskW; d++) begin
      alloc[d] = CW'(d) < CW'(used_q);
    end
    pend_in   = dep_mask_i & alloc & ~done_ext[MaskW-1:0];
    full      = (used_q == UW'(MAX_GROUPS));
    g_idx     = GW'(used_q);
    g_prev    = GrpW'(used_q - UW'(1));
    pend_zero = (pend_q == '0);
    tc_zero   = (tc_q == '0);

    {tot_a, fcnt_a} = rdata_a;
    fcnt_inc = fcnt_a + TcW'(1);
    d_idx    = GW'(dg_q);
    dg_ok    = CW'(dg_q) < CW'(used_q);
    td_rej   = !dg_ok || !disp_q[d_idx] || (fcnt_a == tot_a);
    td_fin   = (fcnt_inc == tot_a);

    walk_start = UW'(CW'(dg_q) + CW'(1));
    start_more = (CW'(dg_q) + CW'(1)) < CW'(used_q);

    {waits_b, dep_b} = rdata_b;
    w_idx    = GW'(widx_q);
    k_cnt    = popcount32(dep_b & fin_q);
    w_hit    = !disp_q[w_idx] && (k_cnt != '0);
    w_new    = (waits_b > k_cnt) ? waits_b - k_cnt : '0;
    w_rel    = w_hit && (w_new == '0);
    w_stall  = w_rel && !stat.push_ok;
    w_zero   = (tot_a == '0);
    w_nxt    = widx_q + UW'(1);
    w_more   = w_nxt < used_q;
    act_walk = active_q - UW'(w_rel && w_zero);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_i)
            OP_SUBMIT: state_d = full ? ST_REJ : ST_SUB;
            OP_DONE:   state_d = ST_TD_CHK;
            OP_CLEAR:  state_d = ST_CLR;
            default:   state_d = ST_REJ;
          endcase
        end
      end
      ST_SUB: begin
        if (stat.push_ok) begin
          state_d = pend_zero ? ST_SUB_RDY : ST_FLUSH;
        end
      end
      ST_SUB_RDY: begin
        if (stat.push_ok) begin
          state_d = (tc_zero && active_q == '0) ? ST_IDLE_EV : ST_FLUSH;
        end
      end
      ST_TD_CHK: begin
        if (td_rej) begin
          state_d = ST_REJ;
        end else begin
          state_d = td_fin ? ST_TD_FIN : ST_TD_ACC;
        end
      end
      ST_TD_FIN: begin
        if (stat.push_ok) begin
          if (start_more) begin
            state_d = ST_WALK;
          end else begin
            state_d = (active_q == '0) ? ST_IDLE_EV : ST_FLUSH;
          end
        end
      end
      ST_WALK: begin
        if (!w_stall && !w_more) begin
          state_d = (act_walk == '0) ? ST_IDLE_EV : ST_FLUSH;
        end
      end
      ST_TD_ACC, ST_IDLE_EV, ST_CLR, ST_REJ: begin
        if (stat.push_ok) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (stat.flush_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    used_d   = used_q;
    active_d = active_q;
    disp_d   = disp_q;
    done_d   = done_q;
    op_d     = op_q;
    tc_d     = tc_q;
    pend_d   = pend_q;
    dg_d     = dg_q;
    total_d  = total_q;
    widx_d   = widx_q;
    fin_d    = fin_q;

    emit       = '0;
    emit.res.ev = EV_ACCEPTED;
    we_a       = 1'b0;
    we_b       = 1'b0;
    waddr_a    = g_idx;
    waddr_b    = g_idx;
    wdata_a    = {tc_q, TcW'(0)};
    wdata_b    = {popcount32(pend_q), pend_q};
    walk_raddr = '0;
    raddr_a    = '0;

    unique case (state_q)
      ST_IDLE: begin
        op_d    = opcode_i;
        tc_d    = TcW'(task_count_i);
        pend_d  = pend_in;
        dg_d    = done_group_i;
        raddr_a = GW'(done_group_i);
      end
      ST_SUB: begin
        emit.push      = 1'b1;
        emit.res.ev    = EV_ACCEPTED;
        emit.res.grp   = GrpW'(used_q);
        if (stat.push_ok) begin
          we_a          = 1'b1;
          we_b          = 1'b1;
          disp_d[g_idx] = pend_zero;
          done_d[g_idx] = pend_zero && tc_zero;
          used_d        = used_q + UW'(1);
          active_d      = active_q + UW'(!(pend_zero && tc_zero));
        end
      end
      ST_SUB_RDY: begin
        emit.push      = 1'b1;
        emit.res.ev    = EV_READY;
        emit.res.grp   = g_prev;
        emit.res.tasks = OutTaskW'(tc_q);
      end
      ST_TD_CHK: begin
        total_d = tot_a;
        waddr_a = d_idx;
        wdata_a = {tot_a, fcnt_inc};
        if (!td_rej) begin
          we_a = 1'b1;
          if (td_fin) begin
            active_d      = active_q - UW'(1);
            done_d[d_idx] = 1'b1;
          end
        end
      end
      ST_TD_ACC: begin
        emit.push    = 1'b1;
        emit.res.ev  = EV_ACCEPTED;
        emit.res.grp = dg_q;
      end
      ST_TD_FIN: begin
        emit.push      = 1'b1;
        emit.res.ev    = EV_FINISHED;
        emit.res.grp   = dg_q;
        emit.res.tasks = OutTaskW'(total_q);
        walk_raddr     = GW'(walk_start);
        raddr_a        = GW'(walk_start);
        if (stat.push_ok) begin
          fin_d  = MaskW'(64'd1 << dg_q);
          widx_d = walk_start;
        end
      end
      ST_WALK: begin
        emit.push      = w_rel;
        emit.res.ev    = EV_READY;
        emit.res.grp   = GrpW'(widx_q);
        emit.res.tasks = OutTaskW'(tot_a);
        waddr_b        = w_idx;
        wdata_b        = {w_new, dep_b};
        raddr_a        = walk_raddr;
        if (w_stall) begin
          walk_raddr = w_idx;
          raddr_a    = w_idx;
        end else begin
          walk_raddr = GW'(w_nxt);
          raddr_a    = GW'(w_nxt);
          widx_d     = w_nxt;
          we_b       = w_hit;
          if (w_rel) begin
            disp_d[w_idx] = 1'b1;
            if (w_zero) begin
              done_d[w_idx] = 1'b1;
              active_d      = act_walk;
              fin_d         = fin_q | MaskW'(64'd1 << widx_q);
            end
          end
        end
      end
      ST_IDLE_EV: begin
        emit.push   = 1'b1;
        emit.res.ev = EV_IDLE;
      end
      ST_CLR: begin
        emit.push   = 1'b1;
        emit.res.ev = (active_q == '0) ? EV_CLEARED : EV_REJECTED;
        if (stat.push_ok && active_q == '0) begin
          used_d = '0;
        end
      end
      ST_REJ: begin
        emit.push    = 1'b1;
        emit.res.ev  = EV_REJECTED;
        emit.res.grp = (op_q == OP_DONE) ? dg_q : '0;
      end
      ST_FLUSH: begin
        emit.flush = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      active_q <= '0;
      disp_q   <= '0;
      done_q   <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      active_q <= active_d;
      disp_q   <= disp_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    tc_q    <= tc_d;
    pend_q  <= pend_d;
    dg_q    <= dg_d;
    total_q <= total_d;
    widx_q  <= widx_d;
    fin_q   <= fin_d;
  end

endmodule

`default_nettype wire

/* rtl/tgds_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module tgds_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/tgds_out.sv */
// result staging register and output register, marks the final result of an item
`default_nettype none

module tgds_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tgds_pkg::emit_t                   emit_i,
  output tgds_pkg::emit_stat_t              stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tgds_pkg::EvW-1:0]          event_res_o,
  output logic [tgds_pkg::GrpW-1:0]         group_num_o,
  output logic [tgds_pkg::OutTaskW-1:0]     group_tasks_o,
  output logic                              last_o
);

  import tgds_pkg::*;

  logic    st_valid_q, st_valid_d;
  result_t st_res_q, st_res_d;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q, out_res_d;
  logic    out_last_q, out_last_d;
  logic    out_free, push_go, flush_go;

  always_comb begin
    out_free        = !out_valid_q || out_ready_i;
    stat_o.push_ok  = !st_valid_q || out_free;
    stat_o.flush_ok = st_valid_q && out_free;
    push_go         = emit_i.push && stat_o.push_ok;
    flush_go        = emit_i.flush && stat_o.flush_ok;

    st_valid_d  = st_valid_q;
    st_res_d    = st_res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    out_last_d  = out_last_q;

    // a staged result moves out once the next one arrives or the item ends
    if ((push_go && st_valid_q) || flush_go) begin
      out_valid_d = 1'b1;
      out_res_d   = st_res_q;
      out_last_d  = flush_go;
    end
    if (push_go) begin
      st_valid_d = 1'b1;
      st_res_d   = emit_i.res;
    end else if (flush_go) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_valid_q  <= st_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_res_q   <= st_res_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = out_res_q.ev;
  assign group_num_o   = out_res_q.grp;
  assign group_tasks_o = out_res_q.tasks;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

/* rtl/tgds_chk.sv */
// port level checks of the task group dependency scheduler and their bind
`default_nettype none

module tgds_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [tgds_pkg::EvW-1:0]      event_res_o,
  input logic [tgds_pkg::GrpW-1:0]     group_num_o,
  input logic [tgds_pkg::OutTaskW-1:0] group_tasks_o,
  input logic                          last_o
);

  import tgds_pkg::*;

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o) &&
      $stable(group_num_o) && $stable(group_tasks_o) && $stable(last_o))
    else $error("stalled result changed");

  // idle and cleared always close an item and carry no group
  a_closing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_IDLE || event_res_o == EV_CLEARED) |->
      last_o && group_num_o == '0 && group_tasks_o == '0)
    else $error("idle or cleared result malformed");

  a_accept_tasks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_ACCEPTED || event_res_o == EV_REJECTED) |->
      group_tasks_o == '0)
    else $error("accepted or rejected result carries a task count");

endmodule

bind task_group_dependency_scheduler tgds_chk u_tgds_chk (.*);

`default_nettype wire

/* bench/task_group_dependency_scheduler_tb.sv */
// self-checking testbench of the task group dependency scheduler: scoreboard class and stimulus
module task_group_dependency_scheduler_tb;
  import tgds_pkg::*;

  localparam int NumGroups = 32;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam int RandomItems = 500;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 60;
  localparam int WaitLimit = 2000;

  typedef struct packed {
    event_e              ev;
    logic [GrpW-1:0]     grp;
    logic [OutTaskW-1:0] tasks;
    logic                last;
  } sched_event_t;

  class group_table_sb;
    int unsigned        alloc_cnt;
    int unsigned        active_cnt;
    logic [InTaskW-1:0] task_total [NumGroups];
    logic [InTaskW-1:0] task_done [NumGroups];
    bit                 dispatched [NumGroups];
    logic [WaitW-1:0]   waits [NumGroups];
    logic [MaskW-1:0]   waits_on [NumGroups];
    sched_event_t       pending_events [$];
    int unsigned        fails;

    function void add_event(event_e ev, int unsigned grp, logic [OutTaskW-1:0] tasks);
      sched_event_t e;
      e.ev = ev;
      e.grp = grp[GrpW-1:0];
      e.tasks = tasks;
      e.last = 1'b0;
      pending_events = {pending_events, e};
    endfunction

    function bit complete(int unsigned g);
      return dispatched[g] && task_done[g] == task_total[g];
    endfunction

    function int busy_group();
      int cand [$];
      for (int g = 0; g < alloc_cnt; g++) begin
        if (dispatched[g] && task_done[g] != task_total[g]) cand = {cand, g};
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function void note_input(logic [OpW-1:0] op, logic [InTaskW-1:0] tc,
                             logic [MaskW-1:0] mask, logic [GrpW-1:0] dg);
      int unsigned      first;
      int unsigned      g;
      int unsigned      k;
      logic [MaskW-1:0] pend;
      logic [MaskW-1:0] finished_set;
      first = pending_events.size();
      case (op)
        OP_SUBMIT: begin
          if (alloc_cnt >= NumGroups) begin
            add_event(EV_REJECTED, 0, '0);
          end else begin
            g = alloc_cnt;
            pend = '0;
            // only allocated groups that are still running count as waits
            for (int d = 0; d < g; d++) begin
              if (mask[d] && !complete(d)) pend[d] = 1'b1;
            end
            task_total[g] = tc;
            task_done[g] = '0;
            dispatched[g] = 1'b0;
            waits_on[g] = pend;
            waits[g] = WaitW'($countones(pend));
            alloc_cnt++;
            active_cnt++;
            add_event(EV_ACCEPTED, g, '0);
            if (waits[g] == 0) begin
              dispatched[g] = 1'b1;
              add_event(EV_READY, g, tc);
              if (tc == 0) begin
                if (active_cnt > 0) active_cnt--;
                if (active_cnt == 0) add_event(EV_IDLE, 0, '0);
              end
            end
          end
        end
        OP_DONE: begin
          if (dg >= alloc_cnt || !dispatched[dg] || task_done[dg] == task_total[dg]) begin
            add_event(EV_REJECTED, dg, '0);
          end else begin
            task_done[dg] = task_done[dg] + 1'b1;
            if (task_done[dg] != task_total[dg]) begin
              add_event(EV_ACCEPTED, dg, '0);
            end else begin
              if (active_cnt > 0) active_cnt--;
              add_event(EV_FINISHED, dg, task_total[dg]);
              finished_set = '0;
              finished_set[dg] = 1'b1;
              // release walk, zero-task groups finish on the spot and release further
              for (int i = dg + 1; i < alloc_cnt; i++) begin
                if (!dispatched[i]) begin
                  k = $countones(waits_on[i] & finished_set);
                  if (k != 0) begin
                    waits[i] = (waits[i] > k) ? WaitW'(waits[i] - k) : '0;
                    if (waits[i] == 0) begin
                      dispatched[i] = 1'b1;
                      add_event(EV_READY, i, task_total[i]);
                      if (task_total[i] == 0) begin
                        if (active_cnt > 0) active_cnt--;
                        finished_set[i] = 1'b1;
                      end
                    end
                  end
                end
              end
              if (active_cnt == 0) add_event(EV_IDLE, 0, '0);
            end
          end
        end
        OP_CLEAR: begin
          if (active_cnt == 0) begin
            alloc_cnt = 0;
            add_event(EV_CLEARED, 0, '0);
          end else begin
            add_event(EV_REJECTED, 0, '0);
          end
        end
        default: begin
          add_event(EV_REJECTED, 0, '0);
        end
      endcase
      if (pending_events.size() > first) pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [EvW-1:0] ev, logic [GrpW-1:0] grp,
                               logic [OutTaskW-1:0] tasks, logic last);
      sched_event_t want;
      if (pending_events.size() == 0) begin
        fails++;
        $display("%0t: unexpected result: expected none, actual event %0d group %0d",
                 $time, ev, grp);
        $display("%0t: unexpected result: actual tasks %0d last %0d", $time, tasks, last);
        return;
      end
      want = pending_events.pop_front();
      if (want.ev != ev) begin
        fails++;
        $display("%0t: event_res mismatch: expected %0d actual %0d", $time, want.ev, ev);
      end
      if (want.grp != grp) begin
        fails++;
        $display("%0t: group_num mismatch: expected %0d actual %0d", $time, want.grp, grp);
      end
      if (want.tasks != tasks) begin
        fails++;
        $display("%0t: group_tasks mismatch: expected %0d actual %0d", $time, want.tasks, tasks);
      end
      if (want.last != last) begin
        fails++;
        $display("%0t: last mismatch: expected %0d actual %0d", $time, want.last, last);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [OpW-1:0]      opcode_i = '0;
  logic [InTaskW-1:0]  task_count_i = '0;
  logic [MaskW-1:0]    dep_mask_i = '0;
  logic [GrpW-1:0]     done_group_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [EvW-1:0]      event_res_o;
  logic [GrpW-1:0]     group_num_o;
  logic [OutTaskW-1:0] group_tasks_o;
  logic                last_o;

  bit            quiet = 1'b0;
  bit            pressure_on = 1'b0;
  int unsigned   tx_gap_pct = 20;
  int unsigned   rx_stall_pct = 20;
  group_table_sb sb;

  task_group_dependency_scheduler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .task_count_i  (task_count_i),
    .dep_mask_i    (dep_mask_i),
    .done_group_i  (done_group_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .group_num_o   (group_num_o),
    .group_tasks_o (group_tasks_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  // outputs are sampled at the falling edge, the transfer completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(event_res_o, group_num_o, group_tasks_o, last_o);
    end
  end

  initial begin : rx_side
    int unsigned hold;
    forever begin
      @(posedge clk_i);
      if (pressure_on) begin
        out_ready_i <= 1'b0;
        for (hold = 0; hold < HoldCycles; hold++) @(posedge clk_i);
        pressure_on = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [OpW-1:0] op, logic [InTaskW-1:0] tc,
                           logic [MaskW-1:0] mask, logic [GrpW-1:0] dg);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    task_count_i <= tc;
    dep_mask_i <= mask;
    done_group_i <= dg;
    do @(negedge clk_i); while (!in_ready_o);
    sb.note_input(op, tc, mask, dg);
    @(posedge clk_i);
    if (!quiet && !pressure_on && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send_done(int g);
    send_item(OP_DONE, InTaskW'($urandom), $urandom, GrpW'(g));
  endtask

  task automatic send_submit_rand();
    logic [InTaskW-1:0] tc;
    logic [MaskW-1:0]   mask;
    logic [MaskW-1:0]   alloc;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (r < 20) tc = '0;
    else if (r < 95) tc = InTaskW'($urandom_range(1, 3));
    else tc = InTaskW'($urandom_range(4, 8));
    alloc = MaskW'((64'd1 << sb.alloc_cnt) - 64'd1);
    if ($urandom_range(0, 3) == 0) mask = $urandom;
    else mask = $urandom & $urandom & alloc;
    send_item(OP_SUBMIT, tc, mask, GrpW'($urandom));
  endtask

  task automatic send_noise();
    if (sb.alloc_cnt == NumGroups && $urandom_range(0, 1) == 1) begin
      send_item(OP_SUBMIT, InTaskW'($urandom), $urandom, GrpW'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0: send_item(OP_UNUSED, InTaskW'($urandom), $urandom, GrpW'($urandom));
        1: send_item(OP_DONE, InTaskW'($urandom), $urandom, GrpW'($urandom));
        default: send_item(OP_CLEAR, InTaskW'($urandom), $urandom, GrpW'($urandom));
      endcase
    end
  endtask

  initial begin : stim
    int          n;
    int          g;
    int          k;
    int unsigned r;
    bit          pressed;
    sb = new();
    pressed = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, bad group, unused opcode
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_DONE, '1, '1, 5'd31);
    send_item(OP_UNUSED, InTaskW'($urandom), $urandom, GrpW'($urandom));
    // chain of dependencies with a zero-task group and unallocated mask bits
    send_item(OP_SUBMIT, 16'd2, '1, '0);
    send_item(OP_SUBMIT, 16'd0, 32'h1, '0);
    send_item(OP_SUBMIT, 16'd1, 32'h3, '0);
    send_item(OP_SUBMIT, 16'd0, 32'h0, '0);
    send_item(OP_SUBMIT, 16'd1, 32'h8, '0);
    send_item(OP_CLEAR, '0, '0, '0);
    send_done(1);
    send_done(3);
    send_done(0);
    send_done(0);
    send_done(2);
    send_done(4);
    send_done(4);
    send_done(5);
    send_item(OP_CLEAR, '1, '1, '1);
    // zero-task group goes idle at once, then depends on a finished group
    send_item(OP_SUBMIT, 16'd0, 32'h0, '0);
    send_item(OP_SUBMIT, 16'd1, 32'h1, '0);
    send_done(0);
    send_done(1);
    send_item(OP_CLEAR, '0, '0, '0);

    n = 0;
    while (n < RandomItems) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 10;
          default: tx_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 10;
          default: rx_stall_pct = 40;
        endcase
      end
      if (n >= 200 && !pressed) begin
        pressed = 1'b1;
        pressure_on = 1'b1;
      end
      r = $urandom_range(0, 99);
      g = sb.busy_group();
      if (r < 8) begin
        send_noise();
      end else begin
        if (sb.active_cnt == 0 && sb.alloc_cnt > 0 && (sb.alloc_cnt == NumGroups || r < 20)) begin
          send_item(OP_CLEAR, InTaskW'($urandom), $urandom, GrpW'($urandom));
        end else if (sb.alloc_cnt < NumGroups && (g < 0 || r < 45)) begin
          send_submit_rand();
        end else begin
          send_done(g);
        end
        n++;
      end
    end

    // no idling from here on: run the table dry, then the largest task counts
    quiet = 1'b1;
    g = sb.busy_group();
    while (g >= 0) begin
      send_done(g);
      g = sb.busy_group();
    end
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_SUBMIT, 16'hFFFF, '0, '0);
    send_item(OP_SUBMIT, 16'h8000, 32'h1, '0);
    send_item(OP_SUBMIT, 16'h7FFF, '0, 5'd31);
    send_done(0);
    send_done(0);
    send_done(0);
    send_done(1);
    send_item(OP_CLEAR, '0, '0, '0);
    in_valid_i <= 1'b0;

    for (k = 0; k < WaitLimit && sb.pending_events.size() != 0; k++) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending_events.size() != 0) begin
      sb.fails++;
      $display("%0t: %0d results missing: expected event %0d group %0d, actual none", $time,
               sb.pending_events.size(), sb.pending_events[0].ev, sb.pending_events[0].grp);
    end
    if (sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
